// File: src/pidl_pkg.sv
// Shared types and constants for the positional insert/delete list.
// No dependencies; imported by pidl_cell and positional_insert_delete_list_top.
`default_nettype none

package pidl_pkg;

	localparam int DEPTH = 64;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int POS_W = 7;
	localparam int VAL_W = 32;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_READ   = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	typedef struct packed {
		logic [1:0]              op;
		logic signed [VAL_W-1:0] value;
		logic [POS_W-1:0]        position;
	} req_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] item_value;
		logic                    is_last;
		logic                    list_empty;
		logic [1:0]              status;
	} rsp_t;

	typedef enum logic [1:0] {
		CMD_HOLD,
		CMD_INSERT,
		CMD_REMOVE,
		CMD_ROTATE
	} cmd_t;

	// Broadcast to every cell of the chain.
	typedef struct packed {
		cmd_t                    cmd;
		logic [IDX_W-1:0]        pidx;      // 0-based target of insert/remove
		logic [IDX_W-1:0]        last_idx;  // last occupied cell during rotate
		logic signed [VAL_W-1:0] ins_value;
	} cell_ctrl_t;

endpackage

`default_nettype wire

// File: src/positional_insert_delete_list_top.sv
// Top level of the positional insert/delete list: control, output register
// and the chain of pidl_cell instances. Depends on pidl_pkg and pidl_cell.
`default_nettype none

// Ordered list of up to DEPTH signed 32-bit values kept in a row of cells.
// Insert and remove requests give one response each with a status; all
// cells shift in parallel. A read-out request gives one response per stored
// entry, front to back, at one per cycle while the output is not stalled
// (a single list_empty response for an empty list): the chain rotates
// through the head cell and is back in order when the last entry leaves.
// No request is taken during a read-out. A finished response sits in an
// output register; the next request is taken while it is being drained.
module positional_insert_delete_list_top (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_stall,
	input  wire pidl_pkg::req_t req,
	output logic                rsp_valid,
	input  wire logic           rsp_stall,
	output pidl_pkg::rsp_t      rsp
);
	import pidl_pkg::*;

	typedef enum logic {
		S_IDLE,
		S_READ
	} state_t;

	state_t                  state_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [CNT_W-1:0]        rd_idx_q;
	logic                    out_valid_q;
	rsp_t                    out_q;

	logic                    out_free;
	logic                    accept;
	logic                    ins_full;
	logic                    ins_range;
	logic                    rem_range;
	logic                    rd_last;
	logic                    idle_rsp;
	logic [1:0]              idle_status;
	logic [IDX_W-1:0]        last_idx;
	cell_ctrl_t              ctrl;
	logic signed [VAL_W-1:0] cell_q [DEPTH];

	assign out_free  = !out_valid_q || !rsp_stall;
	assign req_stall = (state_q != S_IDLE) || !out_free;
	assign accept    = req_valid && !req_stall;
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	assign ins_full  = (32'(cnt_q) == DEPTH);
	assign ins_range = (req.position == '0) || (32'(req.position) > 32'(cnt_q) + 32'd1);
	assign rem_range = (req.position == '0) || (32'(req.position) > 32'(cnt_q));
	assign last_idx  = IDX_W'(cnt_q - CNT_W'(1));
	assign rd_last   = (rd_idx_q == cnt_q - CNT_W'(1));

	// requests answered directly from idle; a non-empty read-out answers later
	assign idle_rsp  = (req.op == OP_INSERT) || (req.op == OP_REMOVE) ||
		((req.op == OP_READ) && (cnt_q == '0));

	always_comb begin
		idle_status = ST_OK;
		if (req.op == OP_INSERT) begin
			if (ins_full) begin
				idle_status = ST_FULL;
			end else if (ins_range) begin
				idle_status = ST_RANGE;
			end
		end else if (req.op == OP_REMOVE && rem_range) begin
			idle_status = ST_RANGE;
		end
	end

	always_comb begin
		ctrl.cmd       = CMD_HOLD;
		ctrl.pidx      = IDX_W'(req.position - POS_W'(1));
		ctrl.last_idx  = last_idx;
		ctrl.ins_value = req.value;
		if (accept) begin
			if (req.op == OP_INSERT && !ins_full && !ins_range) begin
				ctrl.cmd = CMD_INSERT;
			end else if (req.op == OP_REMOVE && !rem_range) begin
				ctrl.cmd = CMD_REMOVE;
			end
		end else if (state_q == S_READ && out_free) begin
			ctrl.cmd = CMD_ROTATE;
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [VAL_W-1:0] prev_v;
		logic signed [VAL_W-1:0] next_v;
		if (i == 0) begin : g_head
			assign prev_v = '0;
		end else begin : g_mid
			assign prev_v = cell_q[i-1];
		end
		if (i == DEPTH - 1) begin : g_tail
			assign next_v = cell_q[i];
		end else begin : g_body
			assign next_v = cell_q[i+1];
		end
		pidl_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.idx        (IDX_W'(i)),
			.prev_value (prev_v),
			.next_value (next_v),
			.head_value (cell_q[0]),
			.value_q    (cell_q[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			rd_idx_q    <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						out_valid_q      <= idle_rsp;
						out_q.item_value <= '0;
						out_q.is_last    <= 1'b1;
						out_q.list_empty <= (req.op == OP_READ);
						out_q.status     <= idle_status;
						case (req.op)
							OP_INSERT: begin
								if (!ins_full && !ins_range) begin
									cnt_q <= cnt_q + CNT_W'(1);
								end
							end
							OP_REMOVE: begin
								if (!rem_range) begin
									cnt_q <= cnt_q - CNT_W'(1);
								end
							end
							OP_READ: begin
								if (cnt_q != '0) begin
									rd_idx_q <= '0;
									state_q  <= S_READ;
								end
							end
							default: begin
							end
						endcase
					end else if (out_free) begin
						out_valid_q <= 1'b0;
					end
				end
				S_READ: begin
					if (out_free) begin
						out_valid_q      <= 1'b1;
						out_q.item_value <= cell_q[0];
						out_q.is_last    <= rd_last;
						out_q.list_empty <= 1'b0;
						out_q.status     <= ST_OK;
						rd_idx_q         <= rd_idx_q + CNT_W'(1);
						if (rd_last) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// File: src/pidl_cell.sv
// One storage cell of the list chain: takes from its left or right neighbor,
// from the head cell, or from the insert value. Depends on pidl_pkg.
`default_nettype none

module pidl_cell (
	input  wire logic                             clk,
	input  wire pidl_pkg::cell_ctrl_t             ctrl,
	input  wire logic [pidl_pkg::IDX_W-1:0]       idx,
	input  wire logic signed [pidl_pkg::VAL_W-1:0] prev_value,
	input  wire logic signed [pidl_pkg::VAL_W-1:0] next_value,
	input  wire logic signed [pidl_pkg::VAL_W-1:0] head_value,
	output logic signed [pidl_pkg::VAL_W-1:0]      value_q
);
	import pidl_pkg::*;

	always_ff @(posedge clk) begin
		case (ctrl.cmd)
			CMD_INSERT: begin
				if (idx == ctrl.pidx) begin
					value_q <= ctrl.ins_value;
				end else if (idx > ctrl.pidx) begin
					value_q <= prev_value;
				end
			end
			CMD_REMOVE: begin
				if (idx >= ctrl.pidx) begin
					value_q <= next_value;
				end
			end
			CMD_ROTATE: begin
				// head wraps to the tail of the occupied part
				if (idx == ctrl.last_idx) begin
					value_q <= head_value;
				end else if (idx < ctrl.last_idx) begin
					value_q <= next_value;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire
